// ----- rtl/urb_pkg.sv -----
// Shared types and codes for the UART ring buffers with loopback echo.
`timescale 1ns / 1ps

package urb_pkg;

  // Event codes as they arrive in the kind field.
  localparam logic [2:0] KIND_SEND  = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_LINE  = 3'd2;
  localparam logic [2:0] KIND_TXRDY = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPBACK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY   = 8'd1;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_SEND,
    OP_READ,
    OP_LINE,
    OP_TXRDY,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic loopback_on;
    logic notify_on;
  } cfg_t;

  // Packed so that status sits in bit 0 and sending in bit 31.
  typedef struct packed {
    logic       sending;
    logic       data_available;
    logic       echo_dropped;
    logic       rx_dropped;
    logic [7:0] notify_byte;
    logic       notify_valid;
    logic [7:0] line_out_byte;
    logic       line_out_valid;
    logic [7:0] read_data;
    logic       read_valid;
    logic       status;
  } res_t;

  typedef enum logic {
    BK_EXEC,
    BK_FILL
  } back_state_t;

endpackage

// ----- rtl/urb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module urb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/urb_front.sv -----
// Front end: accepts event words, classifies the kind and queues them.
`timescale 1ns / 1ps

module urb_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_kind,
  input  logic [7:0]    in_data,
  output logic          q_valid,
  output urb_pkg::item_t q_item,
  input  logic          q_pop
);

  localparam int unsigned QPW = $clog2(urb_pkg::QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(urb_pkg::QUEUE_DEPTH + 1);

  urb_pkg::item_t slots [urb_pkg::QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  urb_pkg::item_t in_item;
  logic           push;

  always_comb begin
    in_item.data = in_data;
    unique case (in_kind)
      urb_pkg::KIND_SEND:  in_item.op = urb_pkg::OP_SEND;
      urb_pkg::KIND_READ:  in_item.op = urb_pkg::OP_READ;
      urb_pkg::KIND_LINE:  in_item.op = urb_pkg::OP_LINE;
      urb_pkg::KIND_TXRDY: in_item.op = urb_pkg::OP_TXRDY;
      urb_pkg::KIND_CLEAR: in_item.op = urb_pkg::OP_CLEAR;
      default:             in_item.op = urb_pkg::OP_NONE;
    endcase
  end

  assign in_ready = (count != QCW'(urb_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(urb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPW'(urb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/urb_back.sv -----
// Back end: executes queued events on the receive and transmit rings.
`timescale 1ns / 1ps

module urb_back #(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  urb_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  urb_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output urb_pkg::res_t  out_res
);

  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW = $clog2(TX_DEPTH);

  urb_pkg::back_state_t state, state_next;

  logic [RX_AW-1:0] rx_wp, rx_wp_next, rx_rp, rx_rp_next, rx_wp_inc, rx_rp_inc;
  logic [TX_AW-1:0] tx_wp, tx_wp_next, tx_rp, tx_rp_next, tx_wp_inc, tx_rp_inc;
  logic             busy, busy_next;

  logic             rx_we, rx_re, tx_we, tx_re;
  logic [7:0]       rx_rdata, tx_rdata;
  logic             go;
  logic             rx_full, tx_full, rx_empty, tx_empty;

  // Result parts known at execute time; read bytes are added at fill.
  logic       pend_status, pend_rd, pend_lo, pend_nv, pend_rxd, pend_ed;
  logic [7:0] pend_nb;
  logic       status_c, rd_c, lo_c, nv_c, rxd_c, ed_c;

  assign rx_wp_inc = (rx_wp == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wp + 1'b1;
  assign rx_rp_inc = (rx_rp == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rp + 1'b1;
  assign tx_wp_inc = (tx_wp == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wp + 1'b1;
  assign tx_rp_inc = (tx_rp == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rp + 1'b1;

  assign rx_full  = (rx_wp_inc == rx_rp);
  assign tx_full  = (tx_wp_inc == tx_rp);
  assign rx_empty = (rx_wp == rx_rp);
  assign tx_empty = (tx_wp == tx_rp);

  // The output slot is free in the fill cycle if it is empty or drains now.
  assign go = q_valid && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      urb_pkg::BK_EXEC: if (go) state_next = urb_pkg::BK_FILL;
      urb_pkg::BK_FILL: state_next = urb_pkg::BK_EXEC;
      default:          state_next = urb_pkg::BK_EXEC;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    tx_we      = 1'b0;
    tx_re      = 1'b0;
    rx_wp_next = rx_wp;
    rx_rp_next = rx_rp;
    tx_wp_next = tx_wp;
    tx_rp_next = tx_rp;
    busy_next  = busy;
    status_c   = 1'b0;
    rd_c       = 1'b0;
    lo_c       = 1'b0;
    nv_c       = 1'b0;
    rxd_c      = 1'b0;
    ed_c       = 1'b0;
    if (state == urb_pkg::BK_EXEC && go) begin
      q_pop = 1'b1;
      unique case (q_item.op)
        urb_pkg::OP_SEND: begin
          if (tx_full) begin
            status_c = 1'b1;
          end else begin
            tx_we      = 1'b1;
            tx_wp_next = tx_wp_inc;
            busy_next  = 1'b1;
          end
        end
        urb_pkg::OP_READ: begin
          if (!rx_empty) begin
            rd_c       = 1'b1;
            rx_re      = 1'b1;
            rx_rp_next = rx_rp_inc;
          end
        end
        urb_pkg::OP_LINE: begin
          if (rx_full) begin
            rxd_c = 1'b1;
          end else begin
            rx_we      = 1'b1;
            rx_wp_next = rx_wp_inc;
            nv_c       = cfg.notify_on;
            if (cfg.loopback_on) begin
              if (tx_full) begin
                ed_c = 1'b1;
              end else begin
                tx_we      = 1'b1;
                tx_wp_next = tx_wp_inc;
                busy_next  = 1'b1;
              end
            end
          end
        end
        urb_pkg::OP_TXRDY: begin
          if (!tx_empty) begin
            lo_c       = 1'b1;
            tx_re      = 1'b1;
            tx_rp_next = tx_rp_inc;
          end else begin
            busy_next = 1'b0;
          end
        end
        urb_pkg::OP_CLEAR: begin
          rx_wp_next = '0;
          rx_rp_next = '0;
          tx_wp_next = '0;
          tx_rp_next = '0;
          busy_next  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  urb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wp),
    .wdata (q_item.data),
    .re    (rx_re),
    .raddr (rx_rp),
    .rdata (rx_rdata)
  );

  urb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wp),
    .wdata (q_item.data),
    .re    (tx_re),
    .raddr (tx_rp),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= urb_pkg::BK_EXEC;
      rx_wp     <= '0;
      rx_rp     <= '0;
      tx_wp     <= '0;
      tx_rp     <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rx_wp <= rx_wp_next;
      rx_rp <= rx_rp_next;
      tx_wp <= tx_wp_next;
      tx_rp <= tx_rp_next;
      busy  <= busy_next;
      if (state == urb_pkg::BK_FILL) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pend_status <= status_c;
      pend_rd     <= rd_c;
      pend_lo     <= lo_c;
      pend_nv     <= nv_c;
      pend_nb     <= nv_c ? q_item.data : 8'd0;
      pend_rxd    <= rxd_c;
      pend_ed     <= ed_c;
    end
    // Pointers are already updated when the fill cycle runs.
    if (state == urb_pkg::BK_FILL) begin
      out_res.status         <= pend_status;
      out_res.read_valid     <= pend_rd;
      out_res.read_data      <= pend_rd ? rx_rdata : 8'd0;
      out_res.line_out_valid <= pend_lo;
      out_res.line_out_byte  <= pend_lo ? tx_rdata : 8'd0;
      out_res.notify_valid   <= pend_nv;
      out_res.notify_byte    <= pend_nb;
      out_res.rx_dropped     <= pend_rxd;
      out_res.echo_dropped   <= pend_ed;
      out_res.data_available <= !rx_empty;
      out_res.sending        <= busy;
    end
  end

endmodule

// ----- rtl/uart_ring_buffers_with_echo.sv -----
// Top level of the UART receive/transmit ring buffers with loopback echo.
`timescale 1ns / 1ps

// Channel   Direction  Signals                          Word
// s_axis    in         tvalid tready tdata[7:0] tuser   one event
// m_axis    out        tvalid tready tdata[31:0]        one result
// cfg       in         valid ready index[7:0] data[7:0] one register write
//
// Each event first updates the rings and issues the ring memory read in the
// exec state, then collects the registered read data in the fill state.
// A two-word event queue lets the input side run ahead of a stalled output.
// Reset clears pointers, busy, queue; loopback on, notify off; RAM kept.
// Configuration writes are taken in every cycle.

module uart_ring_buffers_with_echo #(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // data_byte
  input  logic [2:0]                         s_axis_tuser,  // kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status, read_valid, read_data[8], line_out_valid, line_out_byte[8],
  // notify_valid, notify_byte[8], rx_dropped, echo_dropped,
  // data_available, sending
  output logic [31:0]                        m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [urb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [urb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  urb_pkg::cfg_t  cfg;
  logic           q_valid;
  urb_pkg::item_t q_item;
  logic           q_pop;
  urb_pkg::res_t  out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loopback_on <= 1'b1;
      cfg.notify_on   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        urb_pkg::CFG_LOOPBACK: cfg.loopback_on <= cfg_data[0];
        urb_pkg::CFG_NOTIFY:   cfg.notify_on   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  urb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_kind  (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  urb_back #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = out_res;

endmodule
